### src/circular_deque_defines.svh
// Assertion macros shared by the circular_deque checker.
// No dependencies; expects clk and rst_n in the scope where they are used.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque check failed");

// Next-cycle implication, disabled while in reset.
`define CD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque check failed");

`endif

### src/cd_pkg.sv
// Types and constants for the circular_deque block.
// No dependencies; used by the cell, the top level and the checker.
package cd_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Per-cycle action broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_SHR  = 2'd1,
        OP_SHL  = 2'd2,
        OP_LOAD = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] wdata;
    } cell_ctrl_t;

    localparam logic signed [31:0] DATA_EMPTY = -32'sd1;

endpackage

### src/cd_cmd_if.sv
// Command channel of the circular_deque: valid/ready plus command and value.
// No dependencies.
interface cd_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

### src/cd_rsp_if.sv
// Response channel of the circular_deque: valid/ready plus the result fields.
// No dependencies.
interface cd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [2:0]         count;
    logic               now_full;
    logic               now_empty;

    modport source (output valid, output data, output status, output count,
                    output now_full, output now_empty, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input now_full, input now_empty, output ready);
endinterface

### src/cd_cell.sv
// One storage cell of the deque chain: holds one element and moves it
// to a neighbor on a shift. Depends on cd_pkg.
module cd_cell import cd_pkg::*; #(
    parameter int CW  = 3,
    parameter int IDX = 0
) (
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CW-1:0]     cnt,
    input  logic [31:0]       left,
    input  logic [31:0]       right,
    output logic [31:0]       q,
    output logic [31:0]       rear
);

    logic [31:0] val_reg;
    logic [31:0] val_next;

    always_comb
    begin
        unique case (ctrl.op)
            OP_HOLD: val_next = val_reg;
            OP_SHR:  val_next = left;
            OP_SHL:  val_next = right;
            OP_LOAD: val_next = (cnt == CW'(IDX)) ? ctrl.wdata : val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;
    // Last occupied cell drives the rear bus
    assign rear = (cnt == CW'(IDX + 1)) ? val_reg : '0;

endmodule

### src/circular_deque.sv
// Top level of the circular_deque: command decode, cell chain, result register.
// Depends on cd_pkg, cd_cmd_if, cd_rsp_if and cd_cell.
//
// Double-ended queue of up to DEPTH-1 signed 32-bit elements. Storage is a
// chain of DEPTH-1 cells; the front element always sits in the first cell and
// the rear element in cell count-1. A push at the front shifts the whole chain
// one cell back, a pop at the front shifts it one cell forward, and rear
// accesses touch only one cell at the rear end of the chain. Every command
// yields one result: one command is taken per clock, and its result shows on
// rsp in the cycle after the transfer on cmd. The result register holds a
// stalled result; cmd is ready whenever that register is empty or being
// drained in the same cycle. Push when full and pop or peek when empty are
// rejected with a status code and leave the contents untouched; unused
// command codes only report the current count and flags.
module circular_deque import cd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    cd_cmd_if.sink   cmd,
    cd_rsp_if.source rsp
);

    localparam int CAP = DEPTH - 1;
    localparam int CW  = $clog2(DEPTH);

    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] data_reg;
    logic [1:0]         status_reg;
    logic [2:0]         count_reg;
    logic               full_flag_reg;
    logic               empty_flag_reg;

    logic               accept;
    logic               full;
    logic               empty;
    cell_op_t           op;
    cell_ctrl_t         ctrl;
    logic signed [31:0] data_c;
    status_t            status_c;
    logic [31:0]        front_val;
    logic [31:0]        rear_val;

    logic [31:0] cell_q    [CAP];
    logic [31:0] cell_rear [CAP];

    assign full    = (cnt_reg == CW'(CAP));
    assign empty   = (cnt_reg == '0);
    assign accept  = cmd.valid && cmd.ready;
    assign cmd.ready = !valid_reg || rsp.ready;

    assign front_val = cell_q[0];

    always_comb
    begin
        rear_val = '0;
        for (int k = 0; k < CAP; k++)
        begin
            rear_val = rear_val | cell_rear[k];
        end
    end

    always_comb
    begin
        op       = OP_HOLD;
        cnt_next = cnt_reg;
        data_c   = '0;
        status_c = ST_OK;
        unique case (cmd.command)
            CMD_PUSH_FRONT:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    op       = OP_SHR;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            CMD_PUSH_REAR:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    op       = OP_LOAD;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                    data_c   = DATA_EMPTY;
                end
                else
                begin
                    op       = OP_SHL;
                    cnt_next = cnt_reg - CW'(1);
                    data_c   = front_val;
                end
            end
            CMD_POP_REAR:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                    data_c   = DATA_EMPTY;
                end
                else
                begin
                    // rear cell simply drops out of the occupied range
                    cnt_next = cnt_reg - CW'(1);
                    data_c   = rear_val;
                end
            end
            CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                    data_c   = DATA_EMPTY;
                end
                else
                    data_c = front_val;
            end
            CMD_PEEK_REAR:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                    data_c   = DATA_EMPTY;
                end
                else
                    data_c = rear_val;
            end
            default: ;
        endcase
    end

    assign ctrl.op    = accept ? op : OP_HOLD;
    assign ctrl.wdata = cmd.value;

    genvar i;
    generate
        for (i = 0; i < CAP; i++)
        begin : g_cell
            logic [31:0] left_in;
            logic [31:0] right_in;

            if (i == 0)
            begin : g_first
                assign left_in = cmd.value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_q[i-1];
            end

            if (i == CAP - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_q[i+1];
            end

            cd_cell #(
                .CW  (CW),
                .IDX (i)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .cnt   (cnt_reg),
                .left  (left_in),
                .right (right_in),
                .q     (cell_q[i]),
                .rear  (cell_rear[i])
            );
        end
    endgenerate

    assign valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg       <= data_c;
            status_reg     <= status_c;
            count_reg      <= 3'(cnt_next);
            full_flag_reg  <= (cnt_next == CW'(CAP));
            empty_flag_reg <= (cnt_next == '0);
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.data      = data_reg;
    assign rsp.status    = status_reg;
    assign rsp.count     = count_reg;
    assign rsp.now_full  = full_flag_reg;
    assign rsp.now_empty = empty_flag_reg;

endmodule

### src/cd_checker.sv
// Port-level checker for circular_deque, bound to the top level.
// Depends on cd_pkg and circular_deque_defines.svh.
`include "circular_deque_defines.svh"

module cd_checker import cd_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] data,
    input logic [1:0]         status,
    input logic [2:0]         count,
    input logic               now_full,
    input logic               now_empty
);

    // a stalled result stays put
    `CD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({data, status, count, now_full, now_empty}))

    // no backpressure on cmd while the result register is empty
    `CD_ASSERT_SAME(a_ready_when_idle, !out_valid, in_ready)

    // every cmd transfer yields a result on the next cycle
    `CD_ASSERT_NEXT(a_rsp_follows_cmd, in_valid && in_ready, out_valid)

    `CD_ASSERT_SAME(a_full_reject, out_valid && (status == ST_FULL),
        now_full && (data == '0))

    `CD_ASSERT_SAME(a_empty_reject, out_valid && (status == ST_EMPTY),
        now_empty && (data == DATA_EMPTY) && (count == '0))

endmodule

bind circular_deque cd_checker u_cd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .data      (rsp.data),
    .status    (rsp.status),
    .count     (rsp.count),
    .now_full  (rsp.now_full),
    .now_empty (rsp.now_empty)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque: directed corner cases, then random command streams.
// Depends on cd_pkg, cd_cmd_if, cd_rsp_if and the circular_deque top level.
module tb;
    import cd_pkg::*;

    localparam int DEPTH = 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 80;

    // Codes outside the command set; the block must ignore them
    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;

    typedef struct {
        logic [2:0]         command;
        logic signed [31:0] value;
    } deque_cmd_t;

    typedef struct {
        logic signed [31:0] data;
        status_t            status;
        logic [2:0]         count;
        logic               full;
        logic               empty;
    } deque_result_t;

    logic clk;
    logic rst_n;

    cd_cmd_if cmd_ch ();
    cd_rsp_if rsp_ch ();

    circular_deque #(.DEPTH(DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    deque_cmd_t    cmd_backlog[$];
    deque_result_t predicted_results[$];

    // Shadow deque; 3-bit indices wrap at DEPTH = 8
    logic signed [31:0] ring_store [DEPTH];
    logic [2:0]         front_gap;
    logic [2:0]         rear_idx;

    int  mismatches = 0;
    int  total_items = 0;
    int  cmds_taken = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  cmd_fired = 0;

    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    int  holds_done = 0;
    int  rx_cycle = 0;
    int  rx_mode = 0;

    function automatic deque_result_t deque_step(input deque_cmd_t c);
        deque_result_t r;
        logic [2:0]    next_rear;
        r.data = '0;
        r.status = ST_OK;
        next_rear = rear_idx + 3'd1;
        case (c.command)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (next_rear == front_gap)
                    r.status = ST_FULL;
                else if (c.command == CMD_PUSH_FRONT)
                begin
                    ring_store[front_gap] = c.value;
                    front_gap = front_gap - 3'd1;
                end
                else
                begin
                    rear_idx = next_rear;
                    ring_store[rear_idx] = c.value;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR:
            begin
                if (front_gap == rear_idx)
                begin
                    r.status = ST_EMPTY;
                    r.data = DATA_EMPTY;
                end
                else if (c.command == CMD_POP_FRONT)
                begin
                    front_gap = front_gap + 3'd1;
                    r.data = ring_store[front_gap];
                end
                else if (c.command == CMD_POP_REAR)
                begin
                    r.data = ring_store[rear_idx];
                    rear_idx = rear_idx - 3'd1;
                end
                else if (c.command == CMD_PEEK_FRONT)
                    r.data = ring_store[front_gap + 3'd1];
                else
                    r.data = ring_store[rear_idx];
            end
            default:
            begin
            end
        endcase
        r.count = rear_idx - front_gap;
        r.full = (r.count == 3'(DEPTH - 1));
        r.empty = (r.count == 3'd0);
        return r;
    endfunction

    task automatic queue_cmd(input logic [2:0] c, input logic signed [31:0] v);
        deque_cmd_t item;
        item.command = c;
        item.value = v;
        cmd_backlog.push_back(item);
        total_items++;
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 15))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = '0;
            3: v = -32'sd1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Command driver
    always @(negedge clk)
    begin
        deque_cmd_t item;
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_fired)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                item = cmd_backlog.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.command <= item.command;
                cmd_ch.value <= item.value;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = $urandom_range(0, 6);
                end
            end
            else
                cmd_ch.valid <= 1'b0;
        end
        cmd_fired = 0;
    end

    // Result receiver: switches between stall patterns at random, plus two long hold-offs
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        if (hold_left == 0 && ((holds_done == 0 && results_seen >= 40) ||
                               (holds_done == 1 && results_seen >= 350)))
        begin
            hold_left = LONG_HOLD;
            holds_done++;
        end
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_mode == 0)
            rsp_ch.ready <= 1'b1;
        else if (rx_mode == 1)
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp_ch.ready <= ($urandom_range(0, 1) != 0);
    end

    // Monitor: predict on every command transfer, check every result transfer
    always @(posedge clk)
    begin
        deque_cmd_t    item;
        deque_result_t want;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                item.command = cmd_ch.command;
                item.value = cmd_ch.value;
                predicted_results.push_back(deque_step(item));
                cmds_taken++;
                cmd_fired = 1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, data %0h status %0d", $time,
                             rsp_ch.data, rsp_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("data", want.data, rsp_ch.data);
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("count", 32'(want.count), 32'(rsp_ch.count));
                    check_field("now_full", 32'(want.full), 32'(rsp_ch.now_full));
                    check_field("now_empty", 32'(want.empty), 32'(rsp_ch.now_empty));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         predicted_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int push_weight;
        int r;
        logic [2:0] c;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.value = '0;
        rsp_ch.ready = 1'b0;
        front_gap = '0;
        rear_idx = '0;
        push_weight = 50;

        // Directed: empty errors, ignored codes, fill to full, full errors, drain
        queue_cmd(CMD_PEEK_FRONT, 32'sd5);
        queue_cmd(CMD_PEEK_REAR, 32'sd6);
        queue_cmd(CMD_POP_FRONT, 32'sd7);
        queue_cmd(CMD_POP_REAR, 32'sd8);
        queue_cmd(CMD_RSVD_A, 32'sh12345678);
        queue_cmd(CMD_RSVD_B, -32'sd1);
        queue_cmd(CMD_PUSH_REAR, 32'sh7fffffff);
        queue_cmd(CMD_PUSH_FRONT, 32'sh80000000);
        queue_cmd(CMD_PUSH_REAR, '0);
        queue_cmd(CMD_PUSH_FRONT, -32'sd1);
        queue_cmd(CMD_PUSH_REAR, 32'sd1);
        queue_cmd(CMD_PUSH_FRONT, 32'sh55555555);
        queue_cmd(CMD_PUSH_REAR, 32'shaaaaaaaa);
        queue_cmd(CMD_PUSH_FRONT, 32'sh0badf00d);
        queue_cmd(CMD_PUSH_REAR, 32'sh0badf00d);
        queue_cmd(CMD_RSVD_B, '0);
        queue_cmd(CMD_PEEK_FRONT, '0);
        queue_cmd(CMD_PEEK_REAR, -32'sd1);
        queue_cmd(CMD_POP_FRONT, '0);
        queue_cmd(CMD_POP_REAR, '0);
        queue_cmd(CMD_RSVD_A, '0);
        for (int i = 0; i < 5; i++)
            queue_cmd(CMD_POP_REAR, '0);
        queue_cmd(CMD_POP_REAR, '0);

        // Random: push bias drifts so runs reach full and empty repeatedly
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                push_weight = $urandom_range(20, 80);
            r = $urandom_range(0, 99);
            if (r < 3)
                c = ($urandom_range(0, 1) != 0) ? CMD_RSVD_A : CMD_RSVD_B;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < push_weight)
                    c = ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
                else if (r < push_weight + (100 - push_weight) * 3 / 4)
                    c = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_REAR;
                else
                    c = ($urandom_range(0, 1) != 0) ? CMD_PEEK_FRONT : CMD_PEEK_REAR;
            end
            queue_cmd(c, pick_value());
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmds_taken < total_items || predicted_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (predicted_results.size() > 0)
        begin
            $display("%0t: %0d results never arrived", $time, predicted_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
